// ===== hdl/prwc_pkg.sv =====
// prwc_pkg: shared types and constants for the pll rate word calculator
// used by prwc_div and pll_rate_word_calculator; no dependencies
package prwc_pkg;

   // reference 14.31818 MHz as an integer numerator over 100000
   localparam logic [20:0] FREF_NUM   = 21'd1431818;
   // Q.16 MHz limits
   localparam logic [24:0] F_LOW      = 25'd3276800;   // 50 MHz
   localparam logic [24:0] F_MID      = 25'd5242880;   // 80 MHz
   localparam logic [24:0] F_HIGH     = 25'd9830400;   // 150 MHz
   localparam logic [23:0] ERR_INIT   = 24'd655360;    // 10 MHz
   localparam logic [7:0]  P_FIRST    = 8'd4;
   localparam logic [7:0]  P_LAST     = 8'd130;
   localparam logic [4:0]  WORD_BITS  = 5'd22;
   localparam int          COUNT_POS  = 27;

   localparam logic [1:0]  STATUS_OK   = 2'd0;
   localparam logic [1:0]  STATUS_LOW  = 2'd1;
   localparam logic [1:0]  STATUS_HIGH = 2'd2;

   // divider operand widths
   localparam int DVD_W = 41;
   localparam int DSR_W = 37;
   localparam int QUO_W = 28;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE_WAIT,
      ST_NORM,
      ST_Q_PREP,
      ST_Q_START,
      ST_Q_WAIT,
      ST_F_START,
      ST_F_WAIT,
      ST_EVAL,
      ST_P_NEXT,
      ST_OCT_NEXT,
      ST_RATE_PREP,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_STUFF,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [4:0] steps;   // quotient bits to produce
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/prwc_div.sv =====
// prwc_div: shared restoring divider, one quotient bit per cycle
// depends on prwc_pkg; quotient must fit in the requested number of steps
module prwc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  prwc_pkg::div_ctl_type             ctl,
   input  logic [prwc_pkg::DVD_W-1:0]        dividend,
   input  logic [prwc_pkg::DSR_W-1:0]        divisor,
   output prwc_pkg::div_stat_type            stat,
   output logic [prwc_pkg::QUO_W-1:0]        quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [prwc_pkg::DSR_W:0]    rem_ff, rem_in;
   logic [prwc_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [prwc_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [prwc_pkg::DSR_W-1:0]  dsr_ff, dsr_in;
   logic [prwc_pkg::DSR_W:0]    trial;
   logic                        ge;

   always_comb begin
      trial   = {rem_ff[prwc_pkg::DSR_W-1:0], dvd_ff[prwc_pkg::DVD_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         // upper part is already below the divisor, low bits shift in one per step
         rem_in  = (prwc_pkg::DSR_W+1)'(dividend >> ctl.steps);
         dvd_in  = dividend << (6'(prwc_pkg::DVD_W) - {1'b0, ctl.steps});
         quo_in  = '0;
         cnt_in  = ctl.steps;
         dsr_in  = divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - {1'b0, dsr_ff}) : trial;
         quo_in = {quo_ff[prwc_pkg::QUO_W-2:0], ge};
         dvd_in = {dvd_ff[prwc_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== hdl/pll_rate_word_calculator.sv =====
// pll_rate_word_calculator: sample rate to synthesizer programming word
// an out-of-range rate skips the candidate search; otherwise each P
// candidate takes divider passes of 8 and 24 steps (only the first when Q is out of range),
// 127 candidates per octave, one or two octaves; one word at a time
// req_ready is low from acceptance until the result is loaded into the output register
// reset (synchronous, active high) clears the sequencer, output valid and x128 select
module pll_rate_word_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_requested_rate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_program_word,
   output logic [19:0] rsp_actual_rate,
   output logic [1:0]  rsp_status_code
);

   prwc_pkg::state_type   state_ff, state_in;
   logic                  x128_ff;
   logic [27:0]           fvco_ff, fvco_in;
   logic [3:0]            m_ff, m_in;
   logic [7:0]            p_ff, p_in;
   logic [7:0]            qp_ff, qp_in;
   logic [23:0]           fout_ff, fout_in;
   logic [27:0]           nprod_ff, nprod_in;
   logic [36:0]           dprod_ff, dprod_in;
   logic [23:0]           best_err_ff, best_err_in;
   logic [2:0]            bm_ff, bm_in;
   logic                  bi_ff, bi_in;
   logic [7:0]            bp_ff, bp_in;
   logic [7:0]            bq_ff, bq_in;
   logic [1:0]            status_ff, status_in;
   logic [19:0]           rate_ff, rate_in;
   logic [21:0]           raw_ff, raw_in;
   logic [31:0]           word_ff, word_in;
   logic [4:0]            pos_ff, pos_in;
   logic [1:0]            ones_ff, ones_in;
   logic [4:0]            k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [30:0]           rsp_word_ff, rsp_word_in;
   logic [19:0]           rsp_rate_ff, rsp_rate_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   prwc_pkg::div_ctl_type              div_ctl;
   prwc_pkg::div_stat_type             div_stat;
   logic [prwc_pkg::DVD_W-1:0]         div_dividend;
   logic [prwc_pkg::DSR_W-1:0]         div_divisor;
   logic [prwc_pkg::QUO_W-1:0]         div_quot;

   logic [36:0]           scaled;
   logic [19:0]           qmul;
   logic [13:0]           cmul;
   logic [23:0]           err;
   logic [1:0]            ones_next;
   logic [2:0]            stuff_cnt;

   prwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == prwc_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      fvco_in       = fvco_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      qp_in         = qp_ff;
      fout_in       = fout_ff;
      nprod_in      = nprod_ff;
      dprod_in      = dprod_ff;
      best_err_in   = best_err_ff;
      bm_in         = bm_ff;
      bi_in         = bi_ff;
      bp_in         = bp_ff;
      bq_in         = bq_ff;
      status_in     = status_ff;
      rate_in       = rate_ff;
      raw_in        = raw_ff;
      word_in       = word_ff;
      pos_in        = pos_ff;
      ones_in       = ones_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_status_in = rsp_status_ff;
      div_ctl.start = 1'b0;
      div_ctl.steps = 5'd0;
      div_dividend  = '0;
      div_divisor   = '0;
      scaled        = x128_ff ? {req_requested_rate, 17'd0} : {1'b0, req_requested_rate, 16'd0};
      qmul          = 20'(20'(qp_ff) * 20'd3125);
      cmul          = 14'(14'(bq_ff) * (x128_ff ? 14'd100 : 14'd50));
      err           = (fvco_ff[23:0] > fout_ff) ? (fvco_ff[23:0] - fout_ff)
                                                : (fout_ff - fvco_ff[23:0]);
      ones_next     = raw_ff[k_ff] ? (ones_ff + 2'd1) : 2'd0;
      stuff_cnt     = 3'(pos_ff - prwc_pkg::WORD_BITS);

      unique case (state_ff)
         prwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               // target = round(rate * scale / 1000)
               div_ctl.start = 1'b1;
               div_ctl.steps = 5'd28;
               div_dividend  = 41'(scaled) + 41'd500;
               div_divisor   = 37'd1000;
               m_in          = 4'd0;
               best_err_in   = prwc_pkg::ERR_INIT;
               bm_in         = 3'd4;
               bi_in         = 1'b0;
               bp_in         = 8'd4;
               bq_in         = 8'd4;
               state_in      = prwc_pkg::ST_SCALE_WAIT;
            end
         end
         prwc_pkg::ST_SCALE_WAIT: begin
            if (div_stat.done) begin
               fvco_in  = div_quot;
               state_in = prwc_pkg::ST_NORM;
            end
         end
         prwc_pkg::ST_NORM: begin
            priority if (fvco_ff < 28'(prwc_pkg::F_LOW) && m_ff < 4'd8) begin
               fvco_in = {fvco_ff[26:0], 1'b0};
               m_in    = m_ff + 4'd1;
            end else if (m_ff == 4'd8 || fvco_ff > 28'(prwc_pkg::F_HIGH)) begin
               status_in = (m_ff == 4'd8) ? prwc_pkg::STATUS_LOW : prwc_pkg::STATUS_HIGH;
               word_in   = '0;
               rate_in   = '0;
               pos_in    = prwc_pkg::WORD_BITS;
               state_in  = prwc_pkg::ST_EMIT;
            end else begin
               p_in     = prwc_pkg::P_FIRST;
               state_in = prwc_pkg::ST_Q_PREP;
            end
         end
         prwc_pkg::ST_Q_PREP: begin
            nprod_in = 28'(28'(prwc_pkg::FREF_NUM) * 28'(p_ff));
            dprod_in = 37'(37'd3125 * 37'(fvco_ff[23:0]));
            state_in = prwc_pkg::ST_Q_START;
         end
         prwc_pkg::ST_Q_START: begin
            // q = round(2*fref*p / fvco), scaled to (2N + D) / 2D
            div_ctl.start = 1'b1;
            div_ctl.steps = 5'd8;
            div_dividend  = {nprod_ff, 13'd0} + 41'(dprod_ff);
            div_divisor   = {dprod_ff[35:0], 1'b0};
            state_in      = prwc_pkg::ST_Q_WAIT;
         end
         prwc_pkg::ST_Q_WAIT: begin
            if (div_stat.done) begin
               qp_in = div_quot[7:0];
               if (div_quot[7:0] < 8'd3 || div_quot[7:0] > 8'd128) begin
                  state_in = prwc_pkg::ST_P_NEXT;
               end else begin
                  state_in = prwc_pkg::ST_F_START;
               end
            end
         end
         prwc_pkg::ST_F_START: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = 5'd24;
            div_dividend  = {nprod_ff, 13'd0} + 41'(qmul);
            div_divisor   = 37'({qmul, 1'b0});
            state_in      = prwc_pkg::ST_F_WAIT;
         end
         prwc_pkg::ST_F_WAIT: begin
            if (div_stat.done) begin
               fout_in  = div_quot[23:0];
               state_in = prwc_pkg::ST_EVAL;
            end
         end
         prwc_pkg::ST_EVAL: begin
            if (err < best_err_ff) begin
               best_err_in = err;
               bm_in       = m_ff[2:0];
               bi_in       = (25'(fvco_ff[23:0]) > prwc_pkg::F_MID);
               bp_in       = p_ff;
               bq_in       = qp_ff;
            end
            state_in = prwc_pkg::ST_P_NEXT;
         end
         prwc_pkg::ST_P_NEXT: begin
            if (p_ff == prwc_pkg::P_LAST) begin
               state_in = prwc_pkg::ST_OCT_NEXT;
            end else begin
               p_in     = p_ff + 8'd1;
               state_in = prwc_pkg::ST_Q_PREP;
            end
         end
         prwc_pkg::ST_OCT_NEXT: begin
            if ({fvco_ff[23:0], 1'b0} > prwc_pkg::F_HIGH || m_ff == 4'd7) begin
               state_in = prwc_pkg::ST_RATE_PREP;
            end else begin
               fvco_in  = {fvco_ff[26:0], 1'b0};
               m_in     = m_ff + 4'd1;
               p_in     = prwc_pkg::P_FIRST;
               state_in = prwc_pkg::ST_Q_PREP;
            end
         end
         prwc_pkg::ST_RATE_PREP: begin
            nprod_in = 28'(28'(prwc_pkg::FREF_NUM) * 28'(bp_ff));
            dprod_in = 37'(cmul) << bm_ff;
            state_in = prwc_pkg::ST_RATE_START;
         end
         prwc_pkg::ST_RATE_START: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = 5'd21;
            div_dividend  = 41'(nprod_ff) + 41'(dprod_ff[36:1]);
            div_divisor   = dprod_ff;
            state_in      = prwc_pkg::ST_RATE_WAIT;
         end
         prwc_pkg::ST_RATE_WAIT: begin
            if (div_stat.done) begin
               rate_in   = (div_quot[27:20] != 8'd0) ? 20'hFFFFF : div_quot[19:0];
               raw_in    = {7'(bp_ff - 8'd3), 1'b0, bm_ff, 7'(bq_ff - 8'd2), bi_ff, 3'd0};
               word_in   = '0;
               pos_in    = '0;
               ones_in   = '0;
               k_in      = '0;
               status_in = prwc_pkg::STATUS_OK;
               state_in  = prwc_pkg::ST_STUFF;
            end
         end
         prwc_pkg::ST_STUFF: begin
            // one raw bit per cycle, a zero slot after three ones in a row
            word_in = word_ff | (32'(raw_ff[k_ff]) << pos_ff);
            if (ones_next == 2'd3) begin
               ones_in = 2'd0;
               pos_in  = pos_ff + 5'd2;
            end else begin
               ones_in = ones_next;
               pos_in  = pos_ff + 5'd1;
            end
            if (k_ff == prwc_pkg::WORD_BITS - 5'd1) begin
               state_in = prwc_pkg::ST_EMIT;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         prwc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = word_ff[30:0] | (31'(stuff_cnt) << prwc_pkg::COUNT_POS);
               rsp_rate_in   = rate_ff;
               rsp_status_in = status_ff;
               state_in      = prwc_pkg::ST_IDLE;
            end
         end
         default: state_in = prwc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x128_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            x128_ff <= csr_wr_data;
         end
      end
      fvco_ff       <= fvco_in;
      m_ff          <= m_in;
      p_ff          <= p_in;
      qp_ff         <= qp_in;
      fout_ff       <= fout_in;
      nprod_ff      <= nprod_in;
      dprod_ff      <= dprod_in;
      best_err_ff   <= best_err_in;
      bm_ff         <= bm_in;
      bi_ff         <= bi_in;
      bp_ff         <= bp_in;
      bq_ff         <= bq_in;
      status_ff     <= status_in;
      rate_ff       <= rate_in;
      raw_ff        <= raw_in;
      word_ff       <= word_in;
      pos_ff        <= pos_in;
      ones_ff       <= ones_in;
      k_ff          <= k_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_program_word = rsp_word_ff;
   assign rsp_actual_rate  = rsp_rate_ff;
   assign rsp_status_code  = rsp_status_ff;

endmodule

// ===== hdl/prwc_checker.sv =====
// prwc_checker: port-level checks for pll_rate_word_calculator
// depends on prwc_pkg for the status codes; bound to the top level below
module prwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_program_word,
   input logic [19:0] rsp_actual_rate,
   input logic [1:0]  rsp_status_code
);

   // one word in flight: no second accept right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted word");

   // error results carry an all-zero payload
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code != prwc_pkg::STATUS_OK |-> rsp_program_word == 31'd0
                                            && rsp_actual_rate == 20'd0)
      else $error("error status with nonzero word or rate");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_code <= prwc_pkg::STATUS_HIGH)
      else $error("status code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_program_word)
                                 && $stable(rsp_actual_rate))
      else $error("stalled result word changed");

endmodule

bind pll_rate_word_calculator prwc_checker u_prwc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_program_word (rsp_program_word),
   .rsp_actual_rate  (rsp_actual_rate),
   .rsp_status_code  (rsp_status_code)
);

// ===== verif/pll_rate_word_calculator_tb.sv =====
// pll_rate_word_calculator_tb: self-checking bench for the rate word calculator
// depends on prwc_pkg and pll_rate_word_calculator; predicts each word in-bench
`timescale 1ns / 100ps

module pll_rate_word_calculator_tb;

   localparam int WATCHDOG_LIMIT = 60000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [19:0] req_requested_rate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [30:0] rsp_program_word;
   logic [19:0] rsp_actual_rate;
   logic [1:0]  rsp_status_code;

   typedef struct packed {
      logic [30:0] word;
      logic [19:0] rate;
      logic [1:0]  status;
   } rate_word_type;

   rate_word_type expected_words[$];
   logic       x128_sel = 1'b0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         error_count = 0;
   int         idle_cycles = 0;

   pll_rate_word_calculator u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_requested_rate(req_requested_rate),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_program_word(rsp_program_word), .rsp_actual_rate(rsp_actual_rate),
      .rsp_status_code(rsp_status_code)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic rate_word_type calc_rate_word(logic [19:0] rate_in, logic x128);
      logic [63:0] fvco, num, den, qp, qden, fout, err, best_err;
      logic [63:0] anum, aden, act, word;
      logic [31:0] raw;
      int          oct, bm, bi, bp, bq, idx, pos, ones;
      bit          going;
      rate_word_type res;
      fvco = (64'(rate_in) * (x128 ? 64'd131072 : 64'd65536) + 64'd500) / 64'd1000;
      oct = 0;
      best_err = 64'(prwc_pkg::ERR_INIT);
      bm = 4; bi = 0; bp = 4; bq = 4;
      while (fvco < 64'(prwc_pkg::F_LOW) && oct < 8) begin
         fvco = fvco << 1;
         oct++;
      end
      if (oct == 8 || fvco > 64'(prwc_pkg::F_HIGH)) begin
         res.word = '0;
         res.rate = '0;
         res.status = (oct == 8) ? prwc_pkg::STATUS_LOW : prwc_pkg::STATUS_HIGH;
         return res;
      end
      going = 1'b1;
      while (going) begin
         idx = (fvco > 64'(prwc_pkg::F_MID)) ? 1 : 0;
         for (int p = 4; p <= 130; p++) begin
            num = 64'd2 * 64'(prwc_pkg::FREF_NUM) * 64'(p) * 64'd65536;
            den = 64'd100000 * fvco;
            qp = (64'd2 * num + den) / (64'd2 * den);
            if (qp < 3 || qp > 128) continue;
            qden = 64'd100000 * qp;
            fout = (num + qden / 2) / qden;
            err = (fvco > fout) ? fvco - fout : fout - fvco;
            if (err < best_err) begin
               best_err = err; bm = oct; bi = idx; bp = p; bq = int'(qp);
            end
         end
         if ((fvco << 1) > 64'(prwc_pkg::F_HIGH) || oct == 7) going = 1'b0;
         else begin
            fvco = fvco << 1;
            oct++;
         end
      end
      raw = (32'((bp - 3) & 'h7f) << 15) | (32'(bm & 7) << 11) |
            (32'((bq - 2) & 'h7f) << 4) | (bi ? 32'd8 : 32'd0);
      anum = 64'd2 * 64'(prwc_pkg::FREF_NUM) * 64'(bp) * (x128 ? 64'd500 : 64'd1000);
      aden = (64'd100000 * 64'(bq)) << (bm & 7);
      act = (anum + aden / 2) / aden;
      word = '0; pos = 0; ones = 0;
      for (int k = 0; k < 22; k++) begin
         if (raw[k]) begin
            word[pos] = 1'b1;
            ones++;
         end else ones = 0;
         if (ones == 3) begin
            ones = 0;
            pos++;
         end
         pos++;
      end
      word = word | (64'(pos - 22) << prwc_pkg::COUNT_POS);
      if (act > 64'hfffff) act = 64'hfffff;
      res.word = word[30:0];
      res.rate = act[19:0];
      res.status = prwc_pkg::STATUS_OK;
      return res;
   endfunction

   // valid drops at the accepting edge; the next word is raised at a later edge, never back to back
   task automatic send_rate(logic [19:0] rate_in);
      @(posedge clock);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
         @(posedge clock);
      expected_words.push_back(calc_rate_word(rate_in, x128_sel));
      req_valid <= 1'b1;
      req_requested_rate <= rate_in;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic drain_words();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_oversample(logic x128);
      drain_words();
      csr_wr_en <= 1'b1;
      csr_wr_data <= x128;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      x128_sel = x128;
   endtask

   // response side: random stalls and in-order comparison
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word got %h/%h/%h", $time,
                  rsp_program_word, rsp_actual_rate, rsp_status_code);
               error_count++;
            end else begin
               rate_word_type exp_w;
               exp_w = expected_words.pop_front();
               if (exp_w.word !== rsp_program_word) begin
                  $display("%0t: program_word exp %h got %h", $time, exp_w.word,
                     rsp_program_word);
                  error_count++;
               end
               if (exp_w.rate !== rsp_actual_rate) begin
                  $display("%0t: actual_rate exp %h got %h", $time, exp_w.rate,
                     rsp_actual_rate);
                  error_count++;
               end
               if (exp_w.status !== rsp_status_code) begin
                  $display("%0t: status_code exp %0d got %0d", $time, exp_w.status,
                     rsp_status_code);
                  error_count++;
               end
            end
         end
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("pll_rate_word_calculator_tb: done, errors");
         $finish;
      end
   end

   task automatic test_directed();
      set_oversample(1'b0);
      send_rate(20'd0);
      send_rate(20'hfffff);
      send_rate(20'd760);      // low rate that still normalises into range
      send_rate(20'd195313);   // about 195 MHz target, above the high limit
      send_rate(20'd195312);
      send_rate(20'd585938);   // about 586 MHz target
      send_rate(20'd585937);
      send_rate(20'd312500);   // 312.5 MHz target
      send_rate(20'd312501);
      send_rate(20'd12000);
      send_rate(20'h55555);
      send_rate(20'haaaaa);
      set_oversample(1'b1);
      send_rate(20'd0);
      send_rate(20'hfffff);
      send_rate(20'd97657);
      send_rate(20'd292969);
      send_rate(20'd292968);
      send_rate(20'd380);
      send_rate(20'd24000);
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      set_oversample(1'($urandom_range(1, 0)));
      for (int n = 0; n < count; n++) begin
         // mostly requests from 700 to 600000, some anywhere in the field
         if ($urandom_range(3, 0) != 0) send_rate(20'($urandom_range(600000, 700)));
         else send_rate(20'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(30, 0, 0);
      test_random(30, 83, 0);
      test_random(30, 0, 83);
      test_random(30, 25, 25);
      drain_words();
      if (error_count == 0) $display("pll_rate_word_calculator_tb: done, clean");
      else $display("pll_rate_word_calculator_tb: done, errors");
      $finish;
   end

endmodule

// ===== pll_rate_word_calculator.f =====
hdl/prwc_pkg.sv
hdl/prwc_div.sv
hdl/pll_rate_word_calculator.sv
hdl/prwc_checker.sv
verif/pll_rate_word_calculator_tb.sv
